[rtl/sjs_pkg.sv]
// Shared operation and slot status codes of the job scheduler.
package sjs_pkg;

    typedef enum logic [2:0] {
        OP_REGISTER    = 3'd0,
        OP_UNREGISTER  = 3'd1,
        OP_REQUEST     = 3'd2,
        OP_REQUEST_ALL = 3'd3,
        OP_TAKE_NEXT   = 3'd4,
        OP_TAKE_SLOT   = 3'd5,
        OP_COMPLETE    = 3'd6,
        OP_QUERY       = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_QUEUED    = 3'd1,
        ST_RUNNING   = 3'd2,
        ST_SUCCEEDED = 3'd3,
        ST_FAILED    = 3'd4
    } st_t;

endpackage

[rtl/sync_job_scheduler_core.sv]
// Job scheduler over a table of client slots with a ready queue of slot numbers.
//
// One word is taken at a time and gives exactly one result word. Both the slot table
// and the ready queue sit in synchronous memories with registered reads, and a
// sequencer reads, updates and writes them back. Register, unregister, request,
// complete and query pass through a slot read, an execute state and the output state.
// Request-all visits every slot in ascending order, with a read and an execute per slot.
// Take-next pops queue entries, reading each entry and then its slot,
// discarding stale ones, until it finds a queued slot or the queue runs empty. Take-slot
// on a queued slot compacts the queue, reading each entry held and writing back
// the survivors in their order; on any other slot it goes straight to the output state.
// The slot table carries one valid flop per entry, cleared at reset, so no clearing
// pass is needed; no queue entry beyond its fill is ever used. A finished result
// waits in an output register, so the next word may be accepted while it is pending.
// Slot numbers at or above NUM_SLOTS are refused and query as absent.
module sync_job_scheduler_core
    import sjs_pkg::*;
#(
    parameter int NUM_SLOTS    = 16,
    parameter int QUEUE_DEPTH  = 64,
    parameter int TRIGGER_BITS = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] op,
    input  logic [3:0] slot,
    input  logic [3:0] trigger_bits,
    input  logic       success,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       ok,
    output logic       taken_valid,
    output logic [3:0] taken_slot,
    output logic [4:0] count,
    output logic [2:0] status,
    output logic [3:0] pending,
    output logic       present,
    output logic       overflow
);

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int HW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam int TB = TRIGGER_BITS;
    localparam logic [HW:0]   QD_W      = (HW + 1)'(QUEUE_DEPTH);
    localparam logic [FW-1:0] QD_F      = FW'(QUEUE_DEPTH);
    localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_SLOTS - 1);

    typedef struct packed {
        logic          regd;
        st_t           st;
        logic [TB-1:0] pend;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE, S_SRD, S_SEX, S_FRD, S_FWT, S_PRD, S_PEX, S_PFIN, S_OUT
    } state_t;

    // Wrap an offset around the queue ring.
    function automatic logic [HW-1:0] pos_add(input logic [HW-1:0] a, input logic [HW-1:0] b);
        logic [HW:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= QD_W)
        begin
            sum = sum - QD_W;
        end
        return sum[HW-1:0];
    endfunction

    // Memories and their read registers
    entry_t        smem [NUM_SLOTS];
    logic [SW-1:0] fmem [QUEUE_DEPTH];
    entry_t        s_rd_reg;
    logic          s_rdv_reg;
    logic [SW-1:0] f_rd_reg;
    logic [NUM_SLOTS-1:0] svalid_reg;

    state_t        state_reg;
    op_t           op_reg;
    logic [SW-1:0] addr_reg;
    logic [TB-1:0] trig_reg;
    logic          succ_reg;
    logic [HW-1:0] head_reg;
    logic [FW-1:0] fill_reg;
    logic [FW-1:0] r_reg;
    logic [FW-1:0] w_reg;

    logic          a_ok_reg, a_tv_reg, a_pres_reg, a_ovf_reg;
    logic [SW-1:0] a_ts_reg;
    logic [CW-1:0] a_cnt_reg;
    logic [2:0]    a_st_reg;
    logic [TB-1:0] a_pend_reg;

    logic          out_valid_reg;
    logic          ok_reg, tv_reg, pres_reg, ovf_reg;
    logic [3:0]    ts_reg, pend_reg;
    logic [4:0]    cnt_reg;
    logic [2:0]    st_reg;

    logic          s_we;
    entry_t        s_wdata;
    logic          f_we;
    logic [HW-1:0] f_waddr;
    logic [SW-1:0] f_wdata;
    logic [HW-1:0] f_raddr;

    entry_t        ent;
    logic          full;
    logic [HW-1:0] tail;
    logic          in_range;
    logic          can_req, need_push, req_acc;

    assign in_ready = (state_reg == S_IDLE);
    assign in_range = (32'(slot) < NUM_SLOTS);

    assign ent  = s_rdv_reg ? s_rd_reg : '0;
    assign full = (fill_reg == QD_F);
    assign tail = pos_add(head_reg, fill_reg[HW-1:0]);

    // Request decision, shared by request and request-all
    assign can_req   = ent.regd && (trig_reg != '0) && (ent.st != ST_RUNNING);
    assign need_push = (ent.st != ST_QUEUED);
    assign req_acc   = can_req && !(need_push && full);

    always_comb
    begin
        s_we    = 1'b0;
        s_wdata = '0;
        f_we    = 1'b0;
        f_waddr = tail;
        f_wdata = addr_reg;
        f_raddr = head_reg;
        case (state_reg)
            S_SEX:
            begin
                case (op_reg)
                    OP_REGISTER:
                    begin
                        s_we    = !ent.regd;
                        s_wdata = '{regd: 1'b1, st: ST_IDLE, pend: '0};
                    end
                    OP_UNREGISTER:
                    begin
                        s_we    = ent.regd;
                        s_wdata = '{regd: 1'b0, st: ST_IDLE, pend: '0};
                    end
                    OP_REQUEST, OP_REQUEST_ALL:
                    begin
                        s_we    = req_acc;
                        s_wdata = '{regd: 1'b1, st: ST_QUEUED, pend: ent.pend | trig_reg};
                        f_we    = req_acc && need_push;
                    end
                    OP_TAKE_NEXT:
                    begin
                        s_we    = ent.regd && (ent.st == ST_QUEUED);
                        s_wdata = '{regd: 1'b1, st: ST_RUNNING, pend: '0};
                    end
                    OP_COMPLETE:
                    begin
                        if (ent.regd && (ent.st == ST_RUNNING))
                        begin
                            if (ent.pend != '0)
                            begin
                                s_we    = !full;
                                s_wdata = '{regd: 1'b1, st: ST_QUEUED, pend: ent.pend};
                                f_we    = !full;
                            end
                            else
                            begin
                                s_we    = 1'b1;
                                s_wdata = '{regd: 1'b1,
                                            st: (succ_reg ? ST_SUCCEEDED : ST_FAILED),
                                            pend: '0};
                            end
                        end
                    end
                    default:
                    begin
                        s_we = 1'b0;
                    end
                endcase
            end
            S_PRD:
            begin
                f_raddr = pos_add(head_reg, r_reg[HW-1:0]);
            end
            S_PEX:
            begin
                f_we    = (f_rd_reg != addr_reg);
                f_waddr = pos_add(head_reg, w_reg[HW-1:0]);
                f_wdata = f_rd_reg;
            end
            S_PFIN:
            begin
                s_we    = 1'b1;
                s_wdata = '{regd: 1'b1, st: ST_RUNNING, pend: '0};
            end
            default:
            begin
                s_we = 1'b0;
            end
        endcase
    end

    // Slot table memory
    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            smem[addr_reg] <= s_wdata;
        end
        s_rd_reg <= smem[addr_reg];
    end

    // Ready queue memory
    always_ff @(posedge clk)
    begin
        if (f_we)
        begin
            fmem[f_waddr] <= f_wdata;
        end
        f_rd_reg <= fmem[f_raddr];
    end

    // Sequencer, queue pointers, result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            svalid_reg    <= '0;
            s_rdv_reg     <= 1'b0;
            op_reg        <= OP_REGISTER;
            addr_reg      <= '0;
            trig_reg      <= '0;
            succ_reg      <= 1'b0;
            head_reg      <= '0;
            fill_reg      <= '0;
            r_reg         <= '0;
            w_reg         <= '0;
            a_ok_reg      <= 1'b0;
            a_tv_reg      <= 1'b0;
            a_pres_reg    <= 1'b0;
            a_ovf_reg     <= 1'b0;
            a_ts_reg      <= '0;
            a_cnt_reg     <= '0;
            a_st_reg      <= '0;
            a_pend_reg    <= '0;
            out_valid_reg <= 1'b0;
            ok_reg        <= 1'b0;
            tv_reg        <= 1'b0;
            pres_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            ts_reg        <= '0;
            pend_reg      <= '0;
            cnt_reg       <= '0;
            st_reg        <= '0;
        end
        else
        begin
            s_rdv_reg <= svalid_reg[addr_reg];
            if (s_we)
            begin
                svalid_reg[addr_reg] <= 1'b1;
            end
            // drop the result once taken, unless a new one is loaded this cycle
            if (out_valid_reg && out_ready && (state_reg != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg     <= op_t'(op);
                        addr_reg   <= (op_t'(op) == OP_REQUEST_ALL) ? '0 : SW'(slot);
                        trig_reg   <= TB'(trigger_bits);
                        succ_reg   <= success;
                        a_ok_reg   <= 1'b0;
                        a_tv_reg   <= 1'b0;
                        a_pres_reg <= 1'b0;
                        a_ovf_reg  <= 1'b0;
                        a_ts_reg   <= '0;
                        a_cnt_reg  <= '0;
                        a_st_reg   <= '0;
                        a_pend_reg <= '0;
                        if (op_t'(op) == OP_REQUEST_ALL)
                        begin
                            state_reg <= S_SRD;
                        end
                        else if (op_t'(op) == OP_TAKE_NEXT)
                        begin
                            state_reg <= S_FRD;
                        end
                        else if (in_range)
                        begin
                            state_reg <= S_SRD;
                        end
                        else
                        begin
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_SRD:
                begin
                    state_reg <= S_SEX;
                end
                S_SEX:
                begin
                    case (op_reg)
                        OP_REGISTER:
                        begin
                            a_ok_reg  <= !ent.regd;
                            state_reg <= S_OUT;
                        end
                        OP_UNREGISTER:
                        begin
                            a_ok_reg  <= ent.regd;
                            state_reg <= S_OUT;
                        end
                        OP_REQUEST:
                        begin
                            a_ok_reg  <= req_acc;
                            a_ovf_reg <= can_req && !req_acc;
                            if (f_we)
                            begin
                                fill_reg <= fill_reg + 1'b1;
                            end
                            state_reg <= S_OUT;
                        end
                        OP_REQUEST_ALL:
                        begin
                            a_cnt_reg <= a_cnt_reg + CW'(req_acc);
                            if (can_req && !req_acc)
                            begin
                                a_ovf_reg <= 1'b1;
                            end
                            if (f_we)
                            begin
                                fill_reg <= fill_reg + 1'b1;
                            end
                            // advance to the next slot until the table is done
                            if (addr_reg != LAST_SLOT)
                            begin
                                addr_reg  <= addr_reg + 1'b1;
                                state_reg <= S_SRD;
                            end
                            else
                            begin
                                state_reg <= S_OUT;
                            end
                        end
                        OP_TAKE_NEXT:
                        begin
                            if (s_we)
                            begin
                                a_tv_reg  <= 1'b1;
                                a_ts_reg  <= addr_reg;
                                state_reg <= S_OUT;
                            end
                            else
                            begin
                                state_reg <= S_FRD;
                            end
                        end
                        OP_TAKE_SLOT:
                        begin
                            if (ent.regd && (ent.st == ST_QUEUED))
                            begin
                                r_reg     <= '0;
                                w_reg     <= '0;
                                state_reg <= S_PRD;
                            end
                            else
                            begin
                                state_reg <= S_OUT;
                            end
                        end
                        OP_COMPLETE:
                        begin
                            a_ok_reg <= s_we;
                            a_ovf_reg <= ent.regd && (ent.st == ST_RUNNING)
                                         && (ent.pend != '0) && full;
                            if (f_we)
                            begin
                                fill_reg <= fill_reg + 1'b1;
                            end
                            state_reg <= S_OUT;
                        end
                        default:
                        begin
                            a_pres_reg <= ent.regd;
                            a_st_reg   <= ent.regd ? ent.st : ST_IDLE;
                            a_pend_reg <= ent.regd ? ent.pend : '0;
                            state_reg  <= S_OUT;
                        end
                    endcase
                end
                S_FRD:
                begin
                    // queue empty ends the search with nothing taken
                    state_reg <= (fill_reg == '0) ? S_OUT : S_FWT;
                end
                S_FWT:
                begin
                    addr_reg  <= f_rd_reg;
                    head_reg  <= pos_add(head_reg, HW'(1));
                    fill_reg  <= fill_reg - 1'b1;
                    state_reg <= S_SRD;
                end
                S_PRD:
                begin
                    state_reg <= (r_reg == fill_reg) ? S_PFIN : S_PEX;
                end
                S_PEX:
                begin
                    r_reg <= r_reg + 1'b1;
                    if (f_we)
                    begin
                        w_reg <= w_reg + 1'b1;
                    end
                    state_reg <= S_PRD;
                end
                S_PFIN:
                begin
                    fill_reg  <= w_reg;
                    a_tv_reg  <= 1'b1;
                    a_ts_reg  <= addr_reg;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    // hold until the output register is free
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        ok_reg        <= a_ok_reg;
                        tv_reg        <= a_tv_reg;
                        ts_reg        <= 4'(a_ts_reg);
                        cnt_reg       <= 5'(a_cnt_reg);
                        st_reg        <= a_st_reg;
                        pend_reg      <= 4'(a_pend_reg);
                        pres_reg      <= a_pres_reg;
                        ovf_reg       <= a_ovf_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign ok          = ok_reg;
    assign taken_valid = tv_reg;
    assign taken_slot  = ts_reg;
    assign count       = cnt_reg;
    assign status      = st_reg;
    assign pending     = pend_reg;
    assign present     = pres_reg;
    assign overflow    = ovf_reg;

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= QD_F)
        else $error("queue fill beyond depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (f_we && state_reg == S_SEX) |-> !full)
        else $error("push into a full queue");

    a_purge_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PFIN) |-> (w_reg <= fill_reg))
        else $error("purge kept more entries than it read");

    a_take_running: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PFIN) |=> (a_tv_reg && state_reg == S_OUT))
        else $error("take-slot did not report its slot");
`endif

endmodule

[tb/sv/sync_job_scheduler_core_tb.sv]
// Self-checking testbench for the job scheduler core: directed cases, then random words.
`timescale 1ns / 1ps

module sync_job_scheduler_core_tb
    import sjs_pkg::*;
();

    localparam int SLOTS      = 16;
    localparam int DEPTH      = 64;
    localparam int CYCLE_CAP  = 2000000;
    localparam int DRAIN_WAIT = 300;

    // One result word as the scheduler should return it
    typedef struct packed {
        logic       ok;
        logic       taken_valid;
        logic [3:0] taken_slot;
        logic [4:0] count;
        logic [2:0] status;
        logic [3:0] pending;
        logic       present;
        logic       overflow;
    } sched_result_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [2:0] op;
    logic [3:0] slot;
    logic [3:0] trigger_bits;
    logic       success;
    logic       out_valid;
    logic       out_ready;
    logic       ok;
    logic       taken_valid;
    logic [3:0] taken_slot;
    logic [4:0] count;
    logic [2:0] status;
    logic [3:0] pending;
    logic       present;
    logic       overflow;

    // Shadow copy of the slot table and ready queue
    logic          shadow_reg[SLOTS];
    st_t           shadow_st[SLOTS];
    logic [3:0]    shadow_pend[SLOTS];
    logic [3:0]    shadow_fifo[$];

    sched_result_t expected_results[$];
    int            mismatches;
    int            cycles;
    int            in_idle_pct;
    int            out_idle_pct;

    sync_job_scheduler_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .slot         (slot),
        .trigger_bits (trigger_bits),
        .success      (success),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .ok           (ok),
        .taken_valid  (taken_valid),
        .taken_slot   (taken_slot),
        .count        (count),
        .status       (status),
        .pending      (pending),
        .present      (present),
        .overflow     (overflow)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Request on one slot; mirrors acceptance, coalescing and overflow refusal
    function automatic logic request_slot(input int s, input logic [3:0] trig,
                                          inout logic ovf);
        if (!shadow_reg[s] || trig == 4'd0 || shadow_st[s] == ST_RUNNING)
            return 1'b0;
        if (shadow_st[s] != ST_QUEUED)
        begin
            if (shadow_fifo.size() >= DEPTH)
            begin
                ovf = 1'b1;
                return 1'b0;
            end
            shadow_fifo.push_back(4'(s));
            shadow_st[s] = ST_QUEUED;
        end
        shadow_pend[s] |= trig;
        return 1'b1;
    endfunction

    // Work out the result of one accepted word and advance the shadow state
    function automatic sched_result_t schedule_word(input op_t o, input logic [3:0] s,
                                                   input logic [3:0] trig, input logic succ);
        sched_result_t r;
        logic [3:0]    v;
        logic          ovf;
        r   = '0;
        ovf = 1'b0;
        case (o)
            OP_REGISTER:
                if (!shadow_reg[s])
                begin
                    shadow_reg[s]  = 1'b1;
                    shadow_st[s]   = ST_IDLE;
                    shadow_pend[s] = 4'd0;
                    r.ok = 1'b1;
                end
            OP_UNREGISTER:
                if (shadow_reg[s])
                begin
                    // stale queue entries stay behind
                    shadow_reg[s]  = 1'b0;
                    shadow_st[s]   = ST_IDLE;
                    shadow_pend[s] = 4'd0;
                    r.ok = 1'b1;
                end
            OP_REQUEST:
                r.ok = request_slot(s, trig, ovf);
            OP_REQUEST_ALL:
                for (int i = 0; i < SLOTS; i++)
                    r.count += 5'(request_slot(i, trig, ovf));
            OP_TAKE_NEXT:
                while (shadow_fifo.size() > 0)
                begin
                    v = shadow_fifo.pop_front();
                    if (shadow_reg[v] && shadow_st[v] == ST_QUEUED)
                    begin
                        shadow_st[v]   = ST_RUNNING;
                        shadow_pend[v] = 4'd0;
                        r.taken_valid  = 1'b1;
                        r.taken_slot   = v;
                        break;
                    end
                end
            OP_TAKE_SLOT:
                if (shadow_reg[s] && shadow_st[s] == ST_QUEUED)
                begin
                    for (int i = shadow_fifo.size() - 1; i >= 0; i--)
                        if (shadow_fifo[i] == s)
                            shadow_fifo.delete(i);
                    shadow_st[s]   = ST_RUNNING;
                    shadow_pend[s] = 4'd0;
                    r.taken_valid  = 1'b1;
                    r.taken_slot   = s;
                end
            OP_COMPLETE:
                if (shadow_reg[s] && shadow_st[s] == ST_RUNNING)
                begin
                    if (shadow_pend[s] != 4'd0)
                    begin
                        if (shadow_fifo.size() < DEPTH)
                        begin
                            shadow_fifo.push_back(s);
                            shadow_st[s] = ST_QUEUED;
                            r.ok = 1'b1;
                        end
                        else
                            ovf = 1'b1;
                    end
                    else
                    begin
                        shadow_st[s] = succ ? ST_SUCCEEDED : ST_FAILED;
                        r.ok = 1'b1;
                    end
                end
            default:
                if (shadow_reg[s])
                begin
                    r.present = 1'b1;
                    r.status  = shadow_st[s];
                    r.pending = shadow_pend[s];
                end
        endcase
        r.overflow = ovf;
        return r;
    endfunction

    // Send one word: optional idle gap, then hold valid until the handshake
    task automatic send_word(input op_t o, input logic [3:0] s,
                             input logic [3:0] trig, input logic succ);
        @(negedge clk);
        if ($urandom_range(99) < in_idle_pct)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge clk);
        end
        op           = o;
        slot         = s;
        trigger_bits = trig;
        success      = succ;
        in_valid     = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        expected_results.push_back(schedule_word(o, s, trig, succ));
    endtask

    // Drop valid and hold until every outstanding result has come back
    task automatic wait_for_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Pick a slot in the wanted status where one exists (now and then any slot anyway), else any slot
    function automatic logic [3:0] pick_slot(input st_t want);
        int hits[$];
        for (int i = 0; i < SLOTS; i++)
            if (shadow_reg[i] && shadow_st[i] == want)
                hits.push_back(i);
        if (hits.size() == 0 || $urandom_range(9) == 0)
            return 4'($urandom_range(SLOTS - 1));
        return 4'(hits[$urandom_range(hits.size() - 1)]);
    endfunction

    // Lifecycle of slots 0 and 15 through every status and each refusal
    task automatic test_slot_lifecycle();
        send_word(OP_QUERY, 4'd0, 4'd0, 1'b0);
        send_word(OP_UNREGISTER, 4'd0, 4'd0, 1'b0);
        send_word(OP_TAKE_NEXT, 4'd0, 4'd0, 1'b0);
        send_word(OP_REGISTER, 4'd0, 4'd0, 1'b0);
        send_word(OP_REGISTER, 4'd0, 4'd0, 1'b0);
        send_word(OP_REGISTER, 4'd15, 4'd0, 1'b0);
        send_word(OP_REQUEST, 4'd0, 4'd0, 1'b0);
        send_word(OP_REQUEST, 4'd15, 4'd15, 1'b0);
        send_word(OP_REQUEST, 4'd0, 4'd1, 1'b0);
        send_word(OP_REQUEST, 4'd0, 4'd8, 1'b0);
        send_word(OP_QUERY, 4'd0, 4'd0, 1'b0);
        send_word(OP_TAKE_SLOT, 4'd0, 4'd0, 1'b1);
        send_word(OP_TAKE_SLOT, 4'd0, 4'd0, 1'b1);
        send_word(OP_REQUEST, 4'd0, 4'd2, 1'b0);
        send_word(OP_QUERY, 4'd0, 4'd0, 1'b0);
        send_word(OP_COMPLETE, 4'd0, 4'd0, 1'b1);
        send_word(OP_COMPLETE, 4'd0, 4'd0, 1'b1);
        send_word(OP_TAKE_NEXT, 4'd0, 4'd0, 1'b0);
        send_word(OP_COMPLETE, 4'd15, 4'd0, 1'b0);
        send_word(OP_QUERY, 4'd15, 4'd0, 1'b0);
        send_word(OP_REQUEST_ALL, 4'd0, 4'd5, 1'b0);
        send_word(OP_TAKE_NEXT, 4'd0, 4'd0, 1'b0);
        send_word(OP_UNREGISTER, 4'd0, 4'd0, 1'b0);
        send_word(OP_TAKE_NEXT, 4'd0, 4'd0, 1'b0);
        send_word(OP_QUERY, 4'd0, 4'd0, 1'b0);
    endtask

    // Fill the queue with stale entries, then hit overflow on request and request-all
    task automatic test_queue_overflow();
        send_word(OP_REGISTER, 4'd3, 4'd0, 1'b0);
        for (int i = 0; i < DEPTH; i++)
        begin
            send_word(OP_REQUEST, 4'd3, 4'd1, 1'b0);
            send_word(OP_UNREGISTER, 4'd3, 4'd0, 1'b0);
            send_word(OP_REGISTER, 4'd3, 4'd0, 1'b0);
        end
        send_word(OP_REQUEST, 4'd3, 4'd4, 1'b0);
        send_word(OP_REQUEST_ALL, 4'd0, 4'd15, 1'b0);
        send_word(OP_QUERY, 4'd3, 4'd0, 1'b0);
        send_word(OP_TAKE_SLOT, 4'd3, 4'd0, 1'b0);
        send_word(OP_TAKE_NEXT, 4'd0, 4'd0, 1'b0);
        send_word(OP_REQUEST_ALL, 4'd0, 4'd9, 1'b0);
        send_word(OP_TAKE_NEXT, 4'd0, 4'd0, 1'b0);
    endtask

    // Random words, weighted toward sequences that reach running and completion
    task automatic test_random_traffic(input int words, input int in_pct, input int out_pct);
        int          pick;
        logic [3:0]  trig;
        in_idle_pct  = in_pct;
        out_idle_pct = out_pct;
        for (int n = 0; n < words; n++)
        begin
            pick = $urandom_range(99);
            trig = ($urandom_range(9) == 0) ? 4'd0 : 4'($urandom_range(15));
            if (pick < 10)
                send_word(OP_REGISTER, 4'($urandom_range(15)), trig, 1'($urandom));
            else if (pick < 15)
                send_word(OP_UNREGISTER, 4'($urandom_range(15)), trig, 1'($urandom));
            else if (pick < 35)
                send_word(OP_REQUEST, 4'($urandom_range(15)), trig, 1'($urandom));
            else if (pick < 40)
                send_word(OP_REQUEST_ALL, 4'($urandom_range(15)), trig, 1'($urandom));
            else if (pick < 55)
                send_word(OP_TAKE_NEXT, 4'($urandom_range(15)), trig, 1'($urandom));
            else if (pick < 65)
                send_word(OP_TAKE_SLOT, pick_slot(ST_QUEUED), trig, 1'($urandom));
            else if (pick < 85)
                send_word(OP_COMPLETE, pick_slot(ST_RUNNING), trig, 1'($urandom));
            else
                send_word(OP_QUERY, 4'($urandom_range(15)), trig, 1'($urandom));
            if (n == words / 2)
                wait_for_results();
        end
    endtask

    // Receiver stalls at the configured rate; drive at the falling edge
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= out_idle_pct);

    // Compare each result word with the oldest expectation
    always @(posedge clk)
    begin
        sched_result_t got, want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {ok, taken_valid, taken_slot, count, status, pending, present, overflow};
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h", got);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    // Guard against a hang
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        mismatches   = 0;
        cycles       = 0;
        in_idle_pct  = 0;
        out_idle_pct = 0;
        in_valid     = 1'b0;
        out_ready    = 1'b0;
        op           = OP_REGISTER;
        slot         = 4'd0;
        trigger_bits = 4'd0;
        success      = 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            shadow_reg[i]  = 1'b0;
            shadow_st[i]   = ST_IDLE;
            shadow_pend[i] = 4'd0;
        end
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_slot_lifecycle();
        test_queue_overflow();
        test_random_traffic(290, 28, 82);
        test_random_traffic(290, 82, 28);
        test_random_traffic(290, 0, 0);

        wait_for_results();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[sim.f]
rtl/sjs_pkg.sv
rtl/sync_job_scheduler_core.sv
tb/sv/sync_job_scheduler_core_tb.sv
